[src/dlbp_pkg.sv]
`default_nettype none

package dlbp_pkg;

    // Field widths fixed by the interface
    localparam int ID_W      = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_ADDR_W = 1;
    localparam int FUNC_W    = 2;
    localparam int REQ_W     = 7;
    localparam int MINC_W    = 11;
    localparam int STATUS_W  = 3;

    localparam int DEFAULT_POOL_DEPTH = 1024;
    localparam int RESET_POOL_SIZE    = 1024;
    localparam int BATCH_MAX          = 64;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_POOL_SIZE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SWAP_THR  = 1'd1;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_TAKE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BATCH  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RETURN = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_GRANT   = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NONE    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_REFUSED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_ACCEPT  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_DATA  = 3'b100
    } state_t;

endpackage

`default_nettype wire

[src/double_list_buffer_pool.sv]
`default_nettype none

// Free-buffer pool with two circular lists (a and b) held in two synchronous
// RAMs of POOL_DEPTH entries. One list hands buffer indices out (consumer),
// the other takes returned indices back (producer); the roles swap on a
// single take that finds the consumer empty with the producer above the swap
// threshold, and at most once inside a batch take when the consumer runs
// dry. Writing pool_size reloads list a with 0..pool_size-1 at once: no
// clearing pass is run, the original indices are served until returns
// overwrite them. Timing: s_tready is high while no request is in work and
// the result register is free. A return, a refused batch or an empty take
// loads its result on acceptance. A granting single take reads the RAM on
// acceptance and loads the result once the result register is free. A
// batch is accepted into S_ISSUE, then per granted buffer reads the RAM in
// S_ISSUE and loads the result in S_DATA once the result register is free;
// a list swap or the "none granted" result adds a pass through S_ISSUE.
module double_list_buffer_pool #(
    parameter int POOL_DEPTH = dlbp_pkg::DEFAULT_POOL_DEPTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [dlbp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [dlbp_pkg::CFG_W-1:0]    cfg_wdata,
    // request stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,  // [6:0] req_count, [17:7] min_count,
                                                         // [27:18] buffer_id, [31:28] zero
    input  wire logic [2:0]                    s_tuser,  // [1:0] func, [2] handle_null
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [15:0]                        m_tdata,  // [9:0] granted_id, [15:10] zero
    output logic [3:0]                         m_tuser,  // [2:0] status, [3] grant_valid
    output logic                               m_tlast
);

    localparam int AW    = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int ID_W  = dlbp_pkg::ID_W;
    localparam int RST_CNT = (dlbp_pkg::RESET_POOL_SIZE > POOL_DEPTH) ?
                             POOL_DEPTH : dlbp_pkg::RESET_POOL_SIZE;
    localparam int RST_TAIL = RST_CNT % POOL_DEPTH;

    // request fields
    logic [dlbp_pkg::FUNC_W-1:0] in_func;
    logic [dlbp_pkg::REQ_W-1:0]  in_req;
    logic [dlbp_pkg::MINC_W-1:0] in_minc;
    logic [ID_W-1:0]             in_bid;
    logic                        in_null;

    assign in_req  = s_tdata[6:0];
    assign in_minc = s_tdata[17:7];
    assign in_bid  = s_tdata[27:18];
    assign in_func = s_tuser[1:0];
    assign in_null = s_tuser[2];

    // list RAMs
    logic [ID_W-1:0] mem_a [POOL_DEPTH];
    logic [ID_W-1:0] mem_b [POOL_DEPTH];

    dlbp_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]         pool_cnt_reg, pool_cnt_next;
    logic [dlbp_pkg::CFG_W-1:0] thr_reg, thr_next;
    logic [AW-1:0]            a_head_reg, a_head_next, a_tail_reg, a_tail_next;
    logic [AW-1:0]            b_head_reg, b_head_next, b_tail_reg, b_tail_next;
    logic [CNT_W-1:0]         a_fill_reg, a_fill_next, b_fill_reg, b_fill_next;
    logic                     cons_b_reg, cons_b_next;
    logic [CNT_W-1:0]         a_wcnt_reg, a_wcnt_next;   // writes into list a since reload
    logic [dlbp_pkg::REQ_W-1:0] rem_reg, rem_next;
    logic                     swapped_reg, swapped_next;
    logic                     last_reg, last_next;
    logic                     rd_b_reg, rd_b_next;

    logic                       m_tvalid_reg, m_tvalid_next;
    logic [dlbp_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [ID_W-1:0]            m_id_reg, m_id_next;
    logic                       m_gv_reg, m_gv_next;
    logic                       m_last_reg, m_last_next;

    // RAM read data and the untouched-entry bypass for list a
    logic [ID_W-1:0] a_rdata_reg, b_rdata_reg, a_orig_id_reg;
    logic            a_orig_reg;

    logic            pop_en, pop_b;
    logic            wr_en, wr_b;
    logic [AW-1:0]   wr_addr;
    logic [ID_W-1:0] wr_data;

    logic            out_free;
    logic [CNT_W-1:0] cons_fill, prod_fill;
    logic            take_swap, take_b;
    logic [CNT_W-1:0] take_fill;
    logic [CNT_W-1:0] ret_fill;
    logic [31:0]     a_dist_raw, a_dist;
    logic            a_orig_hit;
    logic [ID_W-1:0] grant_id;
    logic [CNT_W-1:0] cfg_cnt;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(POOL_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + AW'(1);
        end
        return r;
    endfunction

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == dlbp_pkg::S_IDLE) && out_free;
    assign cons_fill = cons_b_reg ? b_fill_reg : a_fill_reg;
    assign prod_fill = cons_b_reg ? a_fill_reg : b_fill_reg;
    assign ret_fill  = prod_fill;

    // single take: swap when the consumer is empty and the producer is above threshold
    assign take_swap = (cons_fill == '0) && (32'(prod_fill) > 32'(thr_reg));
    assign take_b    = cons_b_reg ^ take_swap;
    assign take_fill = take_b ? b_fill_reg : a_fill_reg;

    // an entry of list a still holds its reload index unless the returns written
    // since reload (starting at pool_cnt, wrapping) have reached it; the distance
    // from the first write position wraps at the list depth
    assign a_dist_raw = 32'(a_head_reg) + 32'(POOL_DEPTH) - 32'(pool_cnt_reg);
    assign a_dist     = (a_dist_raw >= 32'(POOL_DEPTH)) ? a_dist_raw - 32'(POOL_DEPTH)
                                                       : a_dist_raw;
    assign a_orig_hit = !(a_dist < 32'(a_wcnt_reg));

    assign grant_id = rd_b_reg ? b_rdata_reg : (a_orig_reg ? a_orig_id_reg : a_rdata_reg);

    assign cfg_cnt = (32'(cfg_wdata) > POOL_DEPTH) ? CNT_W'(POOL_DEPTH) : CNT_W'(cfg_wdata);

    always_comb begin
        state_next    = state_reg;
        pool_cnt_next = pool_cnt_reg;
        thr_next      = thr_reg;
        a_head_next   = a_head_reg;
        a_tail_next   = a_tail_reg;
        a_fill_next   = a_fill_reg;
        b_head_next   = b_head_reg;
        b_tail_next   = b_tail_reg;
        b_fill_next   = b_fill_reg;
        cons_b_next   = cons_b_reg;
        a_wcnt_next   = a_wcnt_reg;
        rem_next      = rem_reg;
        swapped_next  = swapped_reg;
        last_next     = last_reg;
        rd_b_next     = rd_b_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_id_next     = m_id_reg;
        m_gv_next     = m_gv_reg;
        m_last_next   = m_last_reg;
        pop_en        = 1'b0;
        pop_b         = 1'b0;
        wr_en         = 1'b0;
        wr_b          = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;

        case (state_reg)
            dlbp_pkg::S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    case (in_func)
                        dlbp_pkg::FUNC_TAKE: begin
                            cons_b_next = take_b;
                            if (take_fill != '0) begin
                                pop_en     = 1'b1;
                                pop_b      = take_b;
                                last_next  = 1'b1;
                                state_next = dlbp_pkg::S_DATA;
                            end else begin
                                m_tvalid_next = 1'b1;
                                m_status_next = dlbp_pkg::STAT_NONE;
                                m_id_next     = '0;
                                m_gv_next     = 1'b0;
                                m_last_next   = 1'b1;
                            end
                        end
                        dlbp_pkg::FUNC_BATCH: begin
                            if ((32'(a_fill_reg) + 32'(b_fill_reg)) < 32'(in_minc)) begin
                                m_tvalid_next = 1'b1;
                                m_status_next = dlbp_pkg::STAT_REFUSED;
                                m_id_next     = '0;
                                m_gv_next     = 1'b0;
                                m_last_next   = 1'b1;
                            end else begin
                                // clamp the request to the batch limit
                                rem_next     = (32'(in_req) > dlbp_pkg::BATCH_MAX) ?
                                               dlbp_pkg::REQ_W'(dlbp_pkg::BATCH_MAX) : in_req;
                                swapped_next = 1'b0;
                                state_next   = dlbp_pkg::S_ISSUE;
                            end
                        end
                        dlbp_pkg::FUNC_RETURN: begin
                            m_tvalid_next = 1'b1;
                            m_id_next     = '0;
                            m_gv_next     = 1'b0;
                            m_last_next   = 1'b1;
                            if (in_null || (32'(ret_fill) >= POOL_DEPTH)) begin
                                m_status_next = dlbp_pkg::STAT_IGNORED;
                            end else begin
                                m_status_next = dlbp_pkg::STAT_ACCEPT;
                                wr_en   = 1'b1;
                                wr_b    = !cons_b_reg;
                                wr_data = in_bid;
                                if (cons_b_reg) begin
                                    wr_addr     = a_tail_reg;
                                    a_tail_next = wrap_inc(a_tail_reg);
                                    a_fill_next = a_fill_reg + CNT_W'(1);
                                    if (32'(a_wcnt_reg) < POOL_DEPTH) begin
                                        a_wcnt_next = a_wcnt_reg + CNT_W'(1);
                                    end
                                end else begin
                                    wr_addr     = b_tail_reg;
                                    b_tail_next = wrap_inc(b_tail_reg);
                                    b_fill_next = b_fill_reg + CNT_W'(1);
                                end
                            end
                        end
                        default: begin
                            // unused request code: drop it silently
                        end
                    endcase
                end
            end

            dlbp_pkg::S_ISSUE: begin
                if ((rem_reg != '0) && (cons_fill != '0)) begin
                    pop_en     = 1'b1;
                    pop_b      = cons_b_reg;
                    rem_next   = rem_reg - dlbp_pkg::REQ_W'(1);
                    // final grant: request met, or consumer dry with no swap to come
                    last_next  = (rem_reg == dlbp_pkg::REQ_W'(1)) ||
                                 ((cons_fill == CNT_W'(1)) &&
                                  (swapped_reg || (prod_fill == '0)));
                    state_next = dlbp_pkg::S_DATA;
                end else if ((rem_reg != '0) && !swapped_reg && (prod_fill != '0)) begin
                    cons_b_next  = !cons_b_reg;
                    swapped_next = 1'b1;
                end else if (out_free) begin
                    // nothing granted in this batch
                    m_tvalid_next = 1'b1;
                    m_status_next = dlbp_pkg::STAT_NONE;
                    m_id_next     = '0;
                    m_gv_next     = 1'b0;
                    m_last_next   = 1'b1;
                    state_next    = dlbp_pkg::S_IDLE;
                end
            end

            dlbp_pkg::S_DATA: begin
                // read data holds in the RAM output register until the result slot frees
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = dlbp_pkg::STAT_GRANT;
                    m_id_next     = grant_id;
                    m_gv_next     = 1'b1;
                    m_last_next   = last_reg;
                    state_next    = last_reg ? dlbp_pkg::S_IDLE : dlbp_pkg::S_ISSUE;
                end
            end

            default: begin
                state_next = dlbp_pkg::S_IDLE;
            end
        endcase

        if (pop_en) begin
            rd_b_next = pop_b;
            if (pop_b) begin
                b_head_next = wrap_inc(b_head_reg);
                b_fill_next = b_fill_reg - CNT_W'(1);
            end else begin
                a_head_next = wrap_inc(a_head_reg);
                a_fill_next = a_fill_reg - CNT_W'(1);
            end
        end

        if (cfg_wr_en) begin
            case (cfg_addr)
                dlbp_pkg::REG_POOL_SIZE: begin
                    pool_cnt_next = cfg_cnt;
                    a_head_next   = '0;
                    a_tail_next   = (32'(cfg_cnt) == POOL_DEPTH) ? '0 : AW'(cfg_cnt);
                    a_fill_next   = cfg_cnt;
                    b_head_next   = '0;
                    b_tail_next   = '0;
                    b_fill_next   = '0;
                    cons_b_next   = 1'b0;
                    a_wcnt_next   = '0;
                end
                dlbp_pkg::REG_SWAP_THR: begin
                    thr_next = cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dlbp_pkg::S_IDLE;
            pool_cnt_reg <= CNT_W'(RST_CNT);
            thr_reg      <= '0;
            a_head_reg   <= '0;
            a_tail_reg   <= AW'(RST_TAIL);
            a_fill_reg   <= CNT_W'(RST_CNT);
            b_head_reg   <= '0;
            b_tail_reg   <= '0;
            b_fill_reg   <= '0;
            cons_b_reg   <= 1'b0;
            a_wcnt_reg   <= '0;
            rem_reg      <= '0;
            swapped_reg  <= 1'b0;
            last_reg     <= 1'b0;
            rd_b_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pool_cnt_reg <= pool_cnt_next;
            thr_reg      <= thr_next;
            a_head_reg   <= a_head_next;
            a_tail_reg   <= a_tail_next;
            a_fill_reg   <= a_fill_next;
            b_head_reg   <= b_head_next;
            b_tail_reg   <= b_tail_next;
            b_fill_reg   <= b_fill_next;
            cons_b_reg   <= cons_b_next;
            a_wcnt_reg   <= a_wcnt_next;
            rem_reg      <= rem_next;
            swapped_reg  <= swapped_next;
            last_reg     <= last_next;
            rd_b_reg     <= rd_b_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_id_reg     <= m_id_next;
        m_gv_reg     <= m_gv_next;
        m_last_reg   <= m_last_next;
    end

    // list a RAM: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en && !wr_b) begin
            mem_a[wr_addr] <= wr_data;
        end
        if (pop_en && !pop_b) begin
            a_rdata_reg   <= mem_a[a_head_reg];
            a_orig_reg    <= a_orig_hit;
            a_orig_id_reg <= ID_W'(a_head_reg);
        end
    end

    // list b RAM: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en && wr_b) begin
            mem_b[wr_addr] <= wr_data;
        end
        if (pop_en && pop_b) begin
            b_rdata_reg <= mem_b[b_head_reg];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_id_reg};
    assign m_tuser  = {m_gv_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps

// Self-checking bench for the double-list buffer pool.
// A directed table runs first, then random phases under several register
// settings. Every accepted request is fed to a local model of the two lists
// whose results are queued and compared against each result transfer.
module tb_top;

    localparam int DEPTH         = dlbp_pkg::DEFAULT_POOL_DEPTH;
    localparam int SETTLE_CYCLES = 8;     // quiet cycles before a register write
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int HOLD_AT       = 200;   // result transfer count that starts it
    localparam int STALL_LIMIT   = 4000;  // cycles with no transfer at all

    // select value that the block ignores
    localparam logic [dlbp_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [dlbp_pkg::FUNC_W-1:0] func;
        logic [dlbp_pkg::REQ_W-1:0]  req;
        logic [dlbp_pkg::MINC_W-1:0] minc;
        logic [dlbp_pkg::ID_W-1:0]   bid;
        logic                        hnull;
    } pool_req_t;

    typedef struct packed {
        logic [dlbp_pkg::STATUS_W-1:0] status;
        logic [dlbp_pkg::ID_W-1:0]     id;
        logic                          gv;
        logic                          last;
    } pool_res_t;

    typedef struct packed {
        bit                              is_cfg;
        logic [dlbp_pkg::CFG_ADDR_W-1:0] addr;
        logic [dlbp_pkg::CFG_W-1:0]      value;
        pool_req_t                       req;
        bit                              typed;   // res below is the expected single result
        pool_res_t                       res;
    } plan_row_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [dlbp_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [dlbp_pkg::CFG_W-1:0]      cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [31:0]                     s_tdata   = '0;
    logic [2:0]                      s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [15:0]                     m_tdata;
    logic [3:0]                      m_tuser;
    logic                            m_tlast;

    always #10 aclk = ~aclk;

    double_list_buffer_pool dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // ------------------------------------------------------------------
    // Pool model: two circular lists, their pointers and the role flag
    // ------------------------------------------------------------------
    logic [dlbp_pkg::ID_W-1:0] mem_a [DEPTH];
    logic [dlbp_pkg::ID_W-1:0] mem_b [DEPTH];
    int head_a, tail_a, fill_a;
    int head_b, tail_b, fill_b;
    bit cons_b;             // list b currently hands buffers out
    int swap_thr;

    pool_res_t owed_results[$];             // results the pool still owes, oldest first
    logic [dlbp_pkg::ID_W-1:0] held_ids[$]; // granted buffers not yet given back
    plan_row_t plan_rows[$];                // directed table

    int  requests_sent, results_seen, errors;
    int  swap_count, refused_count, dropped_count;
    bit  busy_mode;         // no idling on either side
    bit  hold_done;
    int  hold_left;
    int  stall_run;

    function automatic void reload_lists(int cnt);
        if (cnt > DEPTH) cnt = DEPTH;
        for (int i = 0; i < cnt; i++) mem_a[i] = dlbp_pkg::ID_W'(i);
        head_a = 0;
        tail_a = cnt % DEPTH;
        fill_a = cnt;
        head_b = 0;
        tail_b = 0;
        fill_b = 0;
        cons_b = 1'b0;
        held_ids.delete();
    endfunction

    function automatic int cons_fill();
        return cons_b ? fill_b : fill_a;
    endfunction

    function automatic int prod_fill();
        return cons_b ? fill_a : fill_b;
    endfunction

    function automatic bit cons_pop(output logic [dlbp_pkg::ID_W-1:0] id);
        id = '0;
        if (cons_b) begin
            if (fill_b == 0) return 1'b0;
            id = mem_b[head_b];
            head_b = (head_b + 1) % DEPTH;
            fill_b--;
        end else begin
            if (fill_a == 0) return 1'b0;
            id = mem_a[head_a];
            head_a = (head_a + 1) % DEPTH;
            fill_a--;
        end
        return 1'b1;
    endfunction

    function automatic void owe(logic [dlbp_pkg::STATUS_W-1:0] st,
                                logic [dlbp_pkg::ID_W-1:0] id, logic last);
        pool_res_t r;
        r.status = st;
        r.id     = (st == dlbp_pkg::STAT_GRANT) ? id : '0;
        r.gv     = (st == dlbp_pkg::STAT_GRANT);
        r.last   = last;
        owed_results.insert(owed_results.size(), r);
        if (st == dlbp_pkg::STAT_GRANT) held_ids.insert(held_ids.size(), id);
        if (st == dlbp_pkg::STAT_REFUSED) refused_count++;
    endfunction

    function automatic void add_row(plan_row_t row);
        plan_rows.insert(plan_rows.size(), row);
    endfunction

    // Advance the pool model by one accepted request and queue its results.
    function automatic void pool_serve(pool_req_t r);
        logic [dlbp_pkg::ID_W-1:0] id;
        int want;
        int n;
        pool_res_t tail_res;
        n = 0;
        case (r.func)
            dlbp_pkg::FUNC_TAKE: begin
                // swap roles when the consumer is dry and the producer is over threshold
                if (cons_fill() == 0 && prod_fill() > swap_thr) begin
                    cons_b = !cons_b;
                    swap_count++;
                end
                if (cons_pop(id)) owe(dlbp_pkg::STAT_GRANT, id, 1'b1);
                else owe(dlbp_pkg::STAT_NONE, '0, 1'b1);
            end
            dlbp_pkg::FUNC_BATCH: begin
                want = (r.req > dlbp_pkg::BATCH_MAX) ? dlbp_pkg::BATCH_MAX : int'(r.req);
                if (fill_a + fill_b < int'(r.minc)) begin
                    owe(dlbp_pkg::STAT_REFUSED, '0, 1'b1);
                end else begin
                    while (want > 0 && cons_pop(id)) begin
                        owe(dlbp_pkg::STAT_GRANT, id, 1'b0);
                        n++;
                        want--;
                    end
                    if (want > 0) begin
                        // at most one swap inside a batch
                        if (prod_fill() > 0) begin
                            cons_b = !cons_b;
                            swap_count++;
                        end
                        while (want > 0 && cons_pop(id)) begin
                            owe(dlbp_pkg::STAT_GRANT, id, 1'b0);
                            n++;
                            want--;
                        end
                    end
                    if (n == 0) begin
                        owe(dlbp_pkg::STAT_NONE, '0, 1'b1);
                    end else begin
                        tail_res = owed_results[owed_results.size()-1];
                        tail_res.last = 1'b1;
                        owed_results[owed_results.size()-1] = tail_res;
                    end
                end
            end
            dlbp_pkg::FUNC_RETURN: begin
                if (r.hnull) begin
                    owe(dlbp_pkg::STAT_IGNORED, '0, 1'b1);
                end else if (prod_fill() >= DEPTH) begin
                    // producer full: drop the index
                    owe(dlbp_pkg::STAT_IGNORED, '0, 1'b1);
                    dropped_count++;
                end else begin
                    if (cons_b) begin
                        mem_a[tail_a] = r.bid;
                        tail_a = (tail_a + 1) % DEPTH;
                        fill_a++;
                    end else begin
                        mem_b[tail_b] = r.bid;
                        tail_b = (tail_b + 1) % DEPTH;
                        fill_b++;
                    end
                    owe(dlbp_pkg::STAT_ACCEPT, '0, 1'b1);
                end
            end
            default: ;  // unused select: no result, no state change
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic plan_row_t ask(logic [dlbp_pkg::FUNC_W-1:0] func, int req, int minc,
                                      int bid, bit hnull, bit typed = 1'b0,
                                      logic [dlbp_pkg::STATUS_W-1:0] st = dlbp_pkg::STAT_GRANT,
                                      int id = 0);
        plan_row_t p;
        p           = '0;
        p.req.func  = func;
        p.req.req   = dlbp_pkg::REQ_W'(req);
        p.req.minc  = dlbp_pkg::MINC_W'(minc);
        p.req.bid   = dlbp_pkg::ID_W'(bid);
        p.req.hnull = hnull;
        p.typed     = typed;
        p.res.status = st;
        p.res.id     = dlbp_pkg::ID_W'(id);
        p.res.gv     = (st == dlbp_pkg::STAT_GRANT);
        p.res.last   = 1'b1;
        return p;
    endfunction

    function automatic plan_row_t setreg(logic [dlbp_pkg::CFG_ADDR_W-1:0] addr, int value);
        plan_row_t p;
        p        = '0;
        p.is_cfg = 1'b1;
        p.addr   = addr;
        p.value  = dlbp_pkg::CFG_W'(value);
        return p;
    endfunction

    // Random request, shaped so that returns mostly give back granted buffers
    // and batch minimums often sit right at the free count.
    function automatic pool_req_t draw_request();
        pool_req_t r;
        int pick;
        int total;
        int near;
        int k;
        r.func  = dlbp_pkg::FUNC_TAKE;
        r.req   = dlbp_pkg::REQ_W'($urandom);
        r.minc  = dlbp_pkg::MINC_W'($urandom);
        r.bid   = dlbp_pkg::ID_W'($urandom);
        r.hnull = 1'b0;
        total   = fill_a + fill_b;
        pick    = $urandom_range(99);
        if (pick < 35) begin
            r.func = dlbp_pkg::FUNC_TAKE;
        end else if (pick < 58) begin
            r.func = dlbp_pkg::FUNC_BATCH;
            pick = $urandom_range(99);
            if (pick < 70) r.req = dlbp_pkg::REQ_W'($urandom_range(12));
            else if (pick < 90) r.req = dlbp_pkg::REQ_W'($urandom_range(64, 13));
            else r.req = dlbp_pkg::REQ_W'($urandom_range(127, 65));  // over the clamp
            pick = $urandom_range(99);
            if (pick < 60) begin
                r.minc = dlbp_pkg::MINC_W'($urandom_range(8));
            end else if (pick < 85) begin
                near = total + int'($urandom_range(4)) - 2;
                if (near < 0) near = 0;
                if (near > 2047) near = 2047;
                r.minc = dlbp_pkg::MINC_W'(near);
            end
        end else if (pick < 95) begin
            r.func  = dlbp_pkg::FUNC_RETURN;
            r.hnull = ($urandom_range(99) < 5);
            if (held_ids.size() > 0 && $urandom_range(99) < 75) begin
                k = $urandom_range(held_ids.size() - 1);
                r.bid = held_ids[k];
                held_ids.delete(k);
            end
        end else begin
            r.func  = FUNC_UNUSED;
            r.hnull = 1'($urandom);
        end
        return r;
    endfunction

    // Offer one request, hold it until the transfer, then update the model.
    task automatic send_req(pool_req_t r);
        while (!busy_mode && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, r.bid, r.minc, r.req};
        s_tuser  <= {r.hnull, r.func};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        pool_serve(r);
    endtask

    // Write a register only once the block has drained and settled.
    task automatic write_reg(logic [dlbp_pkg::CFG_ADDR_W-1:0] addr, int value);
        s_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= dlbp_pkg::CFG_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == dlbp_pkg::REG_POOL_SIZE) reload_lists(value & 'h7FF);
        else swap_thr = value & 'h7FF;
    endtask

    // Compare one result transfer with the oldest owed result.
    task automatic check_result();
        pool_res_t want;
        pool_res_t got;
        got.status = m_tuser[2:0];
        got.id     = m_tdata[9:0];
        got.gv     = m_tuser[3];
        got.last   = m_tlast;
        results_seen++;
        if (owed_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, got status=%0d id=%0d gv=%0d last=%0d",
                     $time, got.status, got.id, got.gv, got.last);
            errors++;
        end else begin
            want = owed_results[0];
            owed_results.delete(0);
            if (got.status !== want.status || got.id !== want.id ||
                got.gv !== want.gv || got.last !== want.last) begin
                $display("%0t: mismatch: expected status=%0d id=%0d gv=%0d last=%0d,",
                         $time, want.status, want.id, want.gv, want.last);
                $display("%0t:           got status=%0d id=%0d gv=%0d last=%0d",
                         $time, got.status, got.id, got.gv, got.last);
                errors++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: check each transfer, then pick next cycle's ready
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready) check_result();
            // one long hold-off: the sender keeps offering, so the block backs up
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (busy_mode) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 35);
            end
        end
    end

    // Watchdog: count cycles in which nothing moves on any port.
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid === 1'b1 && m_tready) || cfg_wr_en)
                stall_run = 0;
            else
                stall_run++;
            if (stall_run >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results still owed",
                         $time, stall_run, owed_results.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int pool_val, thr_val, n_items;

        swap_thr = 0;
        reload_lists(dlbp_pkg::RESET_POOL_SIZE);

        // Directed table. From reset list a holds 0..1023 and is the consumer.
        add_row(ask(dlbp_pkg::FUNC_TAKE,   0, 0, 0, 0, 1, dlbp_pkg::STAT_GRANT, 0));
        add_row(ask(dlbp_pkg::FUNC_TAKE,   0, 0, 0, 0, 1, dlbp_pkg::STAT_GRANT, 1));
        add_row(ask(dlbp_pkg::FUNC_BATCH,  3, 0, 0, 0));
        add_row(ask(dlbp_pkg::FUNC_BATCH, 127, 0, 0, 0));           // clamped to 64
        add_row(ask(dlbp_pkg::FUNC_BATCH,  1, 2047, 0, 0, 1, dlbp_pkg::STAT_REFUSED));
        add_row(ask(dlbp_pkg::FUNC_RETURN, 0, 0, 1023, 0, 1, dlbp_pkg::STAT_ACCEPT));
        add_row(ask(dlbp_pkg::FUNC_RETURN, 0, 0, 5, 1, 1, dlbp_pkg::STAT_IGNORED)); // null
        add_row(ask(dlbp_pkg::FUNC_BATCH,  0, 0, 0, 0, 1, dlbp_pkg::STAT_NONE)); // empty request
        add_row(ask(FUNC_UNUSED, 127, 2047, 1023, 1));                   // no result
        add_row(ask(dlbp_pkg::FUNC_TAKE,   0, 0, 0, 0));
        // two-buffer pool with an unreachable threshold
        add_row(setreg(dlbp_pkg::REG_SWAP_THR, 2047));
        add_row(setreg(dlbp_pkg::REG_POOL_SIZE, 2));
        add_row(ask(dlbp_pkg::FUNC_BATCH,  5, 2, 0, 0));            // short batch, no swap
        add_row(ask(dlbp_pkg::FUNC_TAKE,   0, 0, 0, 0, 1, dlbp_pkg::STAT_NONE));
        add_row(ask(dlbp_pkg::FUNC_RETURN, 0, 0, 1023, 0, 1, dlbp_pkg::STAT_ACCEPT));
        // threshold blocks swap
        add_row(ask(dlbp_pkg::FUNC_TAKE,   0, 0, 0, 0, 1, dlbp_pkg::STAT_NONE));
        add_row(ask(dlbp_pkg::FUNC_BATCH,  1, 1, 0, 0));            // batch swaps anyway
        // empty pool
        add_row(setreg(dlbp_pkg::REG_POOL_SIZE, 0));
        add_row(setreg(dlbp_pkg::REG_SWAP_THR, 0));
        add_row(ask(dlbp_pkg::FUNC_TAKE,   0, 0, 0, 0, 1, dlbp_pkg::STAT_NONE));
        add_row(ask(dlbp_pkg::FUNC_BATCH, 64, 0, 0, 0, 1, dlbp_pkg::STAT_NONE));
        add_row(ask(dlbp_pkg::FUNC_RETURN, 0, 0, 'h155, 0, 1, dlbp_pkg::STAT_ACCEPT));
        add_row(ask(dlbp_pkg::FUNC_TAKE,   0, 0, 0, 0));            // swap, grant it back
        add_row(ask(dlbp_pkg::FUNC_BATCH,  1, 1, 0, 0, 1, dlbp_pkg::STAT_REFUSED));
        // oversize pool saturates to full depth
        add_row(setreg(dlbp_pkg::REG_POOL_SIZE, 2047));
        add_row(ask(dlbp_pkg::FUNC_BATCH, 64, 1024, 0, 0));
        add_row(ask(dlbp_pkg::FUNC_BATCH, 64, 1024, 0, 0, 1, dlbp_pkg::STAT_REFUSED));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan_rows[i]) begin
            if (plan_rows[i].is_cfg) begin
                write_reg(plan_rows[i].addr, plan_rows[i].value);
            end else begin
                send_req(plan_rows[i].req);
                // typed rows carry one result; overwrite the model's copy with it
                if (plan_rows[i].typed) owed_results[owed_results.size()-1] = plan_rows[i].res;
            end
        end

        // Random phases under different register settings
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin pool_val = 1024; thr_val = 0; n_items = 100; end
                1: begin
                    pool_val = $urandom_range(16, 1);
                    thr_val  = $urandom_range(8);
                    n_items  = 100;
                end
                2: begin
                    // empty pool: only returned buffers circulate
                    pool_val = 0;
                    thr_val  = $urandom_range(4);
                    n_items  = 60;
                end
                3: begin pool_val = 1; thr_val = 1024; n_items = 80; end
                default: begin
                    pool_val = $urandom_range(2047);
                    thr_val  = $urandom_range(2047);
                    n_items  = 120;
                end
            endcase
            write_reg(dlbp_pkg::REG_POOL_SIZE, pool_val);
            write_reg(dlbp_pkg::REG_SWAP_THR, thr_val);
            busy_mode = (p == 1);
            repeat (n_items) send_req(draw_request());
        end
        busy_mode = 1'b0;

        // Drain and let the block settle before the verdict
        s_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d requests and %0d checked results over several pool sizes,",
                 requests_sent, results_seen);
        $display("with %0d list swaps, %0d refused batches and %0d returns dropped on a full list.",
                 swap_count, refused_count, dropped_count);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
